>>> src/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// shared widths, status codes and the thermistor resistance table
// ----------------------------------------------------------------------------
package ntc_pkg;

   localparam int unsigned MV_W      = 13;
   localparam int unsigned OHM_W     = 20;
   localparam int unsigned RES_W     = 22;
   localparam int unsigned TEMP_W    = 16;
   localparam int unsigned STAT_W    = 2;
   localparam int unsigned KNOWN     = 30;
   localparam int unsigned DEF_ENTRIES = 30;
   // numerator: r*16 (24 bits) times voltage (13 bits)
   localparam int unsigned NUM_W     = 37;
   localparam int unsigned QUO_W     = 38;
   localparam int unsigned DEN_W     = 23;

   localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_COLD = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_HOT  = 2'd2;

   localparam int unsigned CSR_SUPPLY  = 0;
   localparam int unsigned CSR_DIVIDER = 1;
   localparam int unsigned CSR_UPPER   = 2;

   // datasheet resistances in 1/16 ohm, descending; beyond the list the last repeats
   function automatic logic [RES_W-1:0] table_entry(input logic [5:0] idx);
      logic [RES_W-1:0] v;
      unique case (idx)
         6'd0:  v = 22'd3054960 & 22'h3FFFFF;
         6'd1:  v = 22'd2334960;
         6'd2:  v = 22'd1799040;
         6'd3:  v = 22'd1396560;
         6'd4:  v = 22'd1092160;
         6'd5:  v = 22'd860192;
         6'd6:  v = 22'd682176;
         6'd7:  v = 22'd544608;
         6'd8:  v = 22'd437568;
         6'd9:  v = 22'd353728;
         6'd10: v = 22'd287664;
         6'd11: v = 22'd235296;
         6'd12: v = 22'd193504;
         6'd13: v = 22'd160000;
         6'd14: v = 22'd132973;
         6'd15: v = 22'd111058;
         6'd16: v = 22'd93198;
         6'd17: v = 22'd78570;
         6'd18: v = 22'd66533;
         6'd19: v = 22'd56579;
         6'd20: v = 22'd48315;
         6'd21: v = 22'd41421;
         6'd22: v = 22'd35648;
         6'd23: v = 22'd30794;
         6'd24: v = 22'd26694;
         6'd25: v = 22'd23221;
         6'd26: v = 22'd20267;
         6'd27: v = 22'd17747;
         6'd28: v = 22'd15588;
         default: v = 22'd13733;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic load;      // capture input, set up first division
      logic div_step;  // one restoring division step
      logic res_chk;   // latch resistance and range check
      logic scan;      // advance the segment search by one entry
      logic frac_set;  // set up the fraction division
      logic finish;    // form the result
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic pre_fail;   // infinite/hot case known at load
      logic range_fail; // resistance outside the table
      logic scan_done;
   } sts_type;

endpackage

>>> src/ntc_datapath.sv
// ----------------------------------------------------------------------------
// ntc_datapath
// resistance divider, table search and interpolation datapath
// ----------------------------------------------------------------------------
module ntc_datapath #(
   parameter int unsigned TABLE_ENTRIES = ntc_pkg::DEF_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ntc_pkg::MV_W-1:0]      adc_mv,
   input  logic [ntc_pkg::MV_W-1:0]      supply_mv,
   input  logic [ntc_pkg::OHM_W-1:0]     divider_ohms,
   input  logic                          ntc_is_upper,
   input  ntc_pkg::cmd_type              cmd,
   output ntc_pkg::sts_type              sts,
   output logic signed [ntc_pkg::TEMP_W-1:0] temperature,
   output logic [ntc_pkg::STAT_W-1:0]    status
);
   localparam int unsigned N    = (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
   localparam int unsigned IDXW = $clog2(N);
   localparam int unsigned QW   = ntc_pkg::QUO_W;
   localparam int unsigned DW   = ntc_pkg::DEN_W;
   localparam int unsigned CW   = $clog2(QW + 1);

   function automatic logic [ntc_pkg::RES_W-1:0] tab(input logic [IDXW:0] i);
      return ntc_pkg::table_entry(6'(i));
   endfunction

   logic [QW-1:0]  quo_ff, quo_in;      // dividend shifting into quotient
   logic [DW:0]    rem_ff, rem_in;
   logic [DW-1:0]  den_ff, den_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [QW-1:0]  res_ff, res_in;
   logic [IDXW:0]  idx_ff, idx_in;
   logic [ntc_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic signed [ntc_pkg::TEMP_W-1:0] temp_ff, temp_in;
   logic           flat_ff, flat_in;

   logic [ntc_pkg::MV_W-1:0]  vdiff;
   logic [ntc_pkg::OHM_W+3:0] r16;
   logic [DW:0]               trial;
   logic [ntc_pkg::RES_W-1:0] hi, lo, nxt;
   logic signed [31:0]        tsum;

   assign vdiff = supply_mv - adc_mv;
   assign r16   = {divider_ohms, 4'b0};
   assign trial = {rem_ff[DW-1:0], quo_ff[QW-1]} - {1'b0, den_ff};
   assign hi    = tab(idx_ff);
   assign lo    = tab(idx_ff + 1'b1);
   assign nxt   = lo;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      idx_in  = idx_ff;
      stat_in = stat_ff;
      temp_in = temp_ff;
      flat_in = flat_ff;
      tsum    = '0;
      // load: numerator is r16*v plus half the divisor for round to nearest
      if (cmd.load) begin
         rem_in  = '0;
         cnt_in  = CW'(QW);
         idx_in  = '0;
         stat_in = ntc_pkg::STATUS_OK;
         if (ntc_is_upper) begin
            den_in = DW'(adc_mv);
            quo_in = QW'(r16) * QW'(vdiff) + QW'(adc_mv >> 1);
            if (adc_mv == '0) stat_in = ntc_pkg::STATUS_COLD;
            else if (adc_mv >= supply_mv) stat_in = ntc_pkg::STATUS_HOT;
         end else begin
            den_in = DW'(vdiff);
            quo_in = QW'(r16) * QW'(adc_mv) + QW'(vdiff >> 1);
            if (adc_mv >= supply_mv) stat_in = ntc_pkg::STATUS_COLD;
         end
      end
      // restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         if (!trial[DW]) begin
            rem_in = trial;
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DW-1:0], quo_ff[QW-1]};
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
      // range check against first and last entries
      if (cmd.res_chk) begin
         res_in = quo_ff;
         if (quo_ff > QW'(tab('0))) stat_in = ntc_pkg::STATUS_COLD;
         else if (quo_ff < QW'(tab((IDXW+1)'(N-1)))) stat_in = ntc_pkg::STATUS_HOT;
      end
      // segment search
      if (cmd.scan) idx_in = idx_ff + 1'b1;
      // fraction: 1280*(hi-res) + half span over span
      if (cmd.frac_set) begin
         flat_in = !(hi > lo);
         rem_in  = '0;
         cnt_in  = CW'(QW);
         den_in  = DW'(hi - lo);
         quo_in  = QW'(({16'd0, hi} - res_ff[ntc_pkg::RES_W-1:0]) * 11'd1280)
                   + QW'((hi - lo) >> 1);
      end
      if (cmd.finish) begin
         if (stat_ff != ntc_pkg::STATUS_OK) temp_in = '0;
         else begin
            tsum = -32'sd10240 + 32'sd1280 * $signed({1'b0, idx_ff})
                   + (flat_ff ? 32'sd0 : $signed({1'b0, quo_ff[30:0]}));
            if (tsum > 32'sd32767) temp_in = 16'sh7FFF;
            else if (tsum < -32'sd32768) temp_in = -16'sh8000;
            else temp_in = tsum[ntc_pkg::TEMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= ntc_pkg::STATUS_OK;
         cnt_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         stat_ff <= stat_in;
         cnt_ff  <= cnt_in;
         idx_ff  <= idx_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
      temp_ff <= temp_in;
      flat_ff <= flat_in;
   end

   // status back to the controller
   assign sts.div_done   = (cnt_ff == '0);
   assign sts.pre_fail   = (stat_ff != ntc_pkg::STATUS_OK);
   assign sts.range_fail = (stat_in != ntc_pkg::STATUS_OK);
   assign sts.scan_done  = (idx_ff >= (IDXW+1)'(N-2)) || (res_ff >= QW'(nxt));

   assign temperature = temp_ff;
   assign status      = stat_ff;

   // segment index never passes the start of the last table segment
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= (IDXW+1)'(N-2)) else $error("segment index out of range");
   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.frac_set |=> (cnt_ff == CW'(QW))) else $error("fraction division not set up");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && stat_ff != ntc_pkg::STATUS_OK |=> temp_ff == '0)
      else $error("failed conversion must report zero");
endmodule

>>> src/ntc_ctrl.sv
// ----------------------------------------------------------------------------
// ntc_ctrl
// sequencer for division, table search and interpolation
// ----------------------------------------------------------------------------
module ntc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output ntc_pkg::cmd_type cmd,
   input  ntc_pkg::sts_type sts
);
   typedef enum logic [2:0] {
      IDLE, DIV1, CHECK, SCAN, DIV2, FIN, DONE
   } state_type;

   state_type state_ff;
   logic      busy_ff, strobe_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         IDLE:  cmd.load = start;
         DIV1:  cmd.div_step = !sts.div_done;
         CHECK: cmd.res_chk = 1'b1;
         SCAN:  begin
            cmd.scan     = !sts.scan_done;
            cmd.frac_set = sts.scan_done;
         end
         DIV2:  cmd.div_step = !sts.div_done;
         FIN:   cmd.finish = 1'b1;
         DONE:  ;
         default: ;
      endcase
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            IDLE: if (start) begin
               state_ff <= DIV1;
               busy_ff  <= 1'b1;
            end
            DIV1: if (sts.div_done) state_ff <= sts.pre_fail ? FIN : CHECK;
            CHECK: state_ff <= sts.range_fail ? FIN : SCAN;
            SCAN: if (sts.scan_done) state_ff <= DIV2;
            DIV2: if (sts.div_done) state_ff <= FIN;
            FIN: begin
               state_ff  <= DONE;
               strobe_ff <= 1'b1;
            end
            DONE: begin
               state_ff <= IDLE;
               busy_ff  <= 1'b0;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe longer than a cycle");
   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result outside a conversion");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted start did not set busy");
endmodule

>>> src/ntc_lut_temperature_core.sv
// ----------------------------------------------------------------------------
// ntc_lut_temperature_core
// thermistor temperature from a divider voltage by table interpolation
// ----------------------------------------------------------------------------
// A conversion starts when start is high while busy is low and returns one
// result, marked by a one-cycle rsp_strobe that the receiver cannot hold off.
// A conversion runs a division for the resistance, a range check, an
// entry-by-entry table search and a division for the fraction; it stops after
// the first division when the voltage itself shows an open or shorted sensor,
// and after the range check when the resistance falls outside the table. Busy
// drops in the cycle after the result transfer, so the next input transfer
// comes no sooner than that. Both divisions run 38 steps serially, one
// quotient bit per cycle. Configuration must be written only while busy is
// low; the block itself does not enforce it.
module ntc_lut_temperature_core #(
   parameter int unsigned TABLE_ENTRIES = ntc_pkg::DEF_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ntc_pkg::MV_W-1:0]          req_adc_mv,
   output logic                              rsp_strobe,
   output logic signed [ntc_pkg::TEMP_W-1:0] rsp_temperature,
   output logic [ntc_pkg::STAT_W-1:0]        rsp_status,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [ntc_pkg::OHM_W-1:0]         csr_wdata
);
   logic [ntc_pkg::MV_W-1:0]  supply_ff;
   logic [ntc_pkg::OHM_W-1:0] divider_ff;
   logic                      upper_ff;
   ntc_pkg::cmd_type          cmd;
   ntc_pkg::sts_type          sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff  <= 13'd3000;
         divider_ff <= 20'd10000;
         upper_ff   <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == 2'(ntc_pkg::CSR_SUPPLY))
            supply_ff <= csr_wdata[ntc_pkg::MV_W-1:0];
         else if (csr_index == 2'(ntc_pkg::CSR_DIVIDER))
            divider_ff <= csr_wdata;
         else if (csr_index == 2'(ntc_pkg::CSR_UPPER))
            upper_ff <= csr_wdata[0];
      end
   end

   ntc_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .rsp_strobe, .cmd, .sts
   );

   ntc_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock, .reset,
      .adc_mv(req_adc_mv),
      .supply_mv(supply_ff),
      .divider_ohms(divider_ff),
      .ntc_is_upper(upper_ff),
      .cmd, .sts,
      .temperature(rsp_temperature),
      .status(rsp_status)
   );
endmodule
